### design/dfs_pkg.sv
// Shared constants, request and result types and sequencer states for the DFS sorter.
package dfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VERT_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int LINK_W = EDGE_W + 1;
  localparam int STK_W  = VERT_W + LINK_W;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_EDGES);

  // Configuration port geometry and register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(64);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [VERT_W-1:0] src_vertex;
    logic [VERT_W-1:0] dst_vertex;
  } in_req_t;

  typedef struct packed {
    logic [VERT_W-1:0] vertex;
    logic              last;
    logic              error;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ADD1,
    ST_ADD2,
    ST_LEAF,
    ST_SCAN,
    ST_ROOT,
    ST_WALK,
    ST_EDGE,
    ST_PUSH,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage

### design/dfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/dfs_topological_sort.sv
// Add edge: after acceptance the store is updated in ST_ADD1, then ST_ADD2.
// Error result: ST_ERR loads it into the output register once that register is free. Clear and
// the unused command finish on acceptance. Sort: vertices without out-edges are recorded first
// (ST_LEAF), unvisited roots are walked (ST_SCAN to ST_POP), then the record is emitted reversed.
// One request in flight at a time; results leave through an output register.
// Synchronous reset empties the edge lists, drops output valid and sets 64 vertices in use.
module dfs_topological_sort (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dfs_pkg::in_req_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dfs_pkg::out_res_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dfs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [dfs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  dfs_pkg::state_t state, state_next;

  logic [dfs_pkg::CNT_W-1:0]        vertex_count;
  logic [dfs_pkg::CNT_W-1:0]        live_count;
  logic [dfs_pkg::MAX_VERTICES-1:0] nonempty;
  logic [dfs_pkg::EDGE_W:0]         edge_total;
  logic [dfs_pkg::VERT_W-1:0]       add_src;
  logic [dfs_pkg::VERT_W-1:0]       add_dst;
  logic [dfs_pkg::MAX_VERTICES-1:0] visited;
  logic [dfs_pkg::CNT_W-1:0]        vidx;
  logic [dfs_pkg::CNT_W-1:0]        rec;
  logic [dfs_pkg::CNT_W-1:0]        rec_m1;
  logic [dfs_pkg::CNT_W-1:0]        depth;
  logic [dfs_pkg::CNT_W-1:0]        depth_m1;
  logic [dfs_pkg::CNT_W-1:0]        depth_m2;
  logic [dfs_pkg::VERT_W-1:0]       top_vertex;
  logic [dfs_pkg::LINK_W-1:0]       top_cursor;
  logic [dfs_pkg::VERT_W-1:0]       child;
  logic [dfs_pkg::VERT_W-1:0]       emit_idx;

  logic in_accept;
  logic out_free;
  logic cfg_write;
  logic add_bad;
  logic store_full;
  logic cursor_nil;
  logic child_ok;
  logic rec_room;

  // Memory controls
  logic                         tgt_we, tgt_re;
  logic [dfs_pkg::VERT_W-1:0]   tgt_rdata;
  logic                         lnk_we, lnk_re;
  logic [dfs_pkg::EDGE_W-1:0]   lnk_waddr;
  logic [dfs_pkg::LINK_W-1:0]   lnk_wdata, lnk_rdata;
  logic                         head_we, head_re;
  logic [dfs_pkg::VERT_W-1:0]   head_raddr;
  logic [dfs_pkg::EDGE_W-1:0]   head_rdata;
  logic                         tail_we, tail_re;
  logic [dfs_pkg::EDGE_W-1:0]   tail_rdata;
  logic                         post_we, post_re;
  logic [dfs_pkg::VERT_W-1:0]   post_wdata, post_rdata;
  logic                         stk_we, stk_re;
  logic [dfs_pkg::STK_W-1:0]    stk_rdata;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[dfs_pkg::CFG_ADDR_W-1] == dfs_pkg::REG_VERTEX_COUNT);
  assign prdata    = (paddr[dfs_pkg::CFG_ADDR_W-1] == dfs_pkg::REG_VERTEX_COUNT)
                     ? dfs_pkg::CFG_DATA_W'(vertex_count) : '0;

  // Clamp the vertex count into the supported range
  always_comb begin
    if (vertex_count == '0) begin
      live_count = dfs_pkg::CNT_W'(1);
    end else if (vertex_count > dfs_pkg::CNT_W'(dfs_pkg::MAX_VERTICES)) begin
      live_count = dfs_pkg::CNT_W'(dfs_pkg::MAX_VERTICES);
    end else begin
      live_count = vertex_count;
    end
  end

  assign in_stall   = (state != dfs_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign store_full = (edge_total == (dfs_pkg::EDGE_W + 1)'(dfs_pkg::MAX_EDGES));
  assign add_bad    = ({1'b0, in_data.src_vertex} >= live_count)
                      || ({1'b0, in_data.dst_vertex} >= live_count) || store_full;
  assign cursor_nil = (top_cursor == dfs_pkg::NIL_LINK);
  assign child_ok   = ({1'b0, tgt_rdata} < live_count) && !visited[tgt_rdata]
                      && (depth < dfs_pkg::CNT_W'(dfs_pkg::MAX_VERTICES));
  assign rec_room   = (rec < dfs_pkg::CNT_W'(dfs_pkg::MAX_VERTICES));
  assign rec_m1     = rec - dfs_pkg::CNT_W'(1);
  assign depth_m1   = depth - dfs_pkg::CNT_W'(1);
  assign depth_m2   = depth - dfs_pkg::CNT_W'(2);

  // Next state and memory strobes
  always_comb begin
    state_next = state;
    tgt_we     = 1'b0;
    tgt_re     = 1'b0;
    lnk_we     = 1'b0;
    lnk_re     = 1'b0;
    lnk_waddr  = edge_total[dfs_pkg::EDGE_W-1:0];
    lnk_wdata  = dfs_pkg::NIL_LINK;
    head_we    = 1'b0;
    head_re    = 1'b0;
    head_raddr = vidx[dfs_pkg::VERT_W-1:0];
    tail_we    = 1'b0;
    tail_re    = 1'b0;
    post_we    = 1'b0;
    post_re    = 1'b0;
    post_wdata = top_vertex;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    unique case (state)
      dfs_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.cmd)
            dfs_pkg::CMD_ADD:    state_next = add_bad ? dfs_pkg::ST_ERR : dfs_pkg::ST_ADD1;
            dfs_pkg::CMD_SORT:   state_next = dfs_pkg::ST_LEAF;
            dfs_pkg::CMD_CLEAR,
            dfs_pkg::CMD_UNUSED: state_next = dfs_pkg::ST_IDLE;
          endcase
        end
      end
      dfs_pkg::ST_ERR: begin
        if (out_free) begin
          state_next = dfs_pkg::ST_IDLE;
        end
      end
      dfs_pkg::ST_ADD1: begin
        // Store target, terminate link, start head or fetch tail
        tgt_we     = 1'b1;
        lnk_we     = 1'b1;
        head_we    = !nonempty[add_src];
        tail_re    = nonempty[add_src];
        state_next = dfs_pkg::ST_ADD2;
      end
      dfs_pkg::ST_ADD2: begin
        // Chain old tail to the new edge
        lnk_we     = nonempty[add_src];
        lnk_waddr  = tail_rdata;
        lnk_wdata  = {1'b0, edge_total[dfs_pkg::EDGE_W-1:0]};
        tail_we    = 1'b1;
        state_next = dfs_pkg::ST_IDLE;
      end
      dfs_pkg::ST_LEAF: begin
        if (vidx == live_count) begin
          state_next = dfs_pkg::ST_SCAN;
        end else begin
          post_we    = !nonempty[vidx[dfs_pkg::VERT_W-1:0]];
          post_wdata = vidx[dfs_pkg::VERT_W-1:0];
        end
      end
      dfs_pkg::ST_SCAN: begin
        if (vidx == live_count) begin
          state_next = dfs_pkg::ST_EMIT_RD;
        end else if (!visited[vidx[dfs_pkg::VERT_W-1:0]]) begin
          head_re    = 1'b1;
          state_next = dfs_pkg::ST_ROOT;
        end
      end
      dfs_pkg::ST_ROOT: begin
        state_next = dfs_pkg::ST_WALK;
      end
      dfs_pkg::ST_WALK: begin
        if (depth == '0) begin
          state_next = dfs_pkg::ST_SCAN;
        end else if (cursor_nil) begin
          // Finish the top vertex and pop
          post_we = rec_room;
          if (depth > dfs_pkg::CNT_W'(1)) begin
            stk_re     = 1'b1;
            state_next = dfs_pkg::ST_POP;
          end
        end else begin
          tgt_re     = 1'b1;
          lnk_re     = 1'b1;
          state_next = dfs_pkg::ST_EDGE;
        end
      end
      dfs_pkg::ST_EDGE: begin
        if (child_ok) begin
          head_re    = 1'b1;
          head_raddr = tgt_rdata;
          state_next = dfs_pkg::ST_PUSH;
        end else begin
          state_next = dfs_pkg::ST_WALK;
        end
      end
      dfs_pkg::ST_PUSH: begin
        stk_we     = 1'b1;
        state_next = dfs_pkg::ST_WALK;
      end
      dfs_pkg::ST_POP: begin
        state_next = dfs_pkg::ST_WALK;
      end
      dfs_pkg::ST_EMIT_RD: begin
        post_re    = 1'b1;
        state_next = dfs_pkg::ST_EMIT_WR;
      end
      dfs_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          state_next = (emit_idx == '0) ? dfs_pkg::ST_IDLE : dfs_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = dfs_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: config, list occupancy, edge count, walk depth, visited marks
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dfs_pkg::VCOUNT_RESET;
      nonempty     <= '0;
      edge_total   <= '0;
      depth        <= '0;
      visited      <= '0;
    end else begin
      if (cfg_write) begin
        vertex_count <= pwdata[dfs_pkg::CNT_W-1:0];
      end
      unique case (state)
        dfs_pkg::ST_IDLE: begin
          if (in_accept && in_data.cmd == dfs_pkg::CMD_CLEAR) begin
            nonempty   <= '0;
            edge_total <= '0;
          end
          if (in_accept && in_data.cmd == dfs_pkg::CMD_SORT) begin
            visited <= '0;
            depth   <= '0;
          end
        end
        dfs_pkg::ST_ADD2: begin
          nonempty[add_src] <= 1'b1;
          edge_total        <= edge_total + (dfs_pkg::EDGE_W + 1)'(1);
        end
        dfs_pkg::ST_LEAF: begin
          if (vidx != live_count && !nonempty[vidx[dfs_pkg::VERT_W-1:0]]) begin
            visited[vidx[dfs_pkg::VERT_W-1:0]] <= 1'b1;
          end
        end
        dfs_pkg::ST_ROOT: begin
          visited[vidx[dfs_pkg::VERT_W-1:0]] <= 1'b1;
          depth <= dfs_pkg::CNT_W'(1);
        end
        dfs_pkg::ST_WALK: begin
          if (depth != '0 && cursor_nil) begin
            depth <= depth - dfs_pkg::CNT_W'(1);
          end
        end
        dfs_pkg::ST_PUSH: begin
          visited[child] <= 1'b1;
          depth          <= depth + dfs_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Walk datapath: scan index, record count, top of stack, emit index
  always_ff @(posedge clk) begin
    unique case (state)
      dfs_pkg::ST_IDLE: begin
        add_src <= in_data.src_vertex;
        add_dst <= in_data.dst_vertex;
        vidx    <= '0;
        rec     <= '0;
      end
      dfs_pkg::ST_LEAF: begin
        if (vidx == live_count) begin
          vidx <= '0;
        end else begin
          vidx <= vidx + dfs_pkg::CNT_W'(1);
          if (!nonempty[vidx[dfs_pkg::VERT_W-1:0]]) begin
            rec <= rec + dfs_pkg::CNT_W'(1);
          end
        end
      end
      dfs_pkg::ST_SCAN: begin
        if (vidx == live_count) begin
          emit_idx <= rec_m1[dfs_pkg::VERT_W-1:0];
        end else if (visited[vidx[dfs_pkg::VERT_W-1:0]]) begin
          vidx <= vidx + dfs_pkg::CNT_W'(1);
        end
      end
      dfs_pkg::ST_ROOT: begin
        top_vertex <= vidx[dfs_pkg::VERT_W-1:0];
        top_cursor <= nonempty[vidx[dfs_pkg::VERT_W-1:0]] ? {1'b0, head_rdata}
                                                            : dfs_pkg::NIL_LINK;
        vidx       <= vidx + dfs_pkg::CNT_W'(1);
      end
      dfs_pkg::ST_WALK: begin
        if (depth != '0 && cursor_nil && rec_room) begin
          rec <= rec + dfs_pkg::CNT_W'(1);
        end
      end
      dfs_pkg::ST_EDGE: begin
        // Advance the cursor past this edge
        top_cursor <= lnk_rdata;
        child      <= tgt_rdata;
      end
      dfs_pkg::ST_PUSH: begin
        top_vertex <= child;
        top_cursor <= nonempty[child] ? {1'b0, head_rdata} : dfs_pkg::NIL_LINK;
      end
      dfs_pkg::ST_POP: begin
        {top_vertex, top_cursor} <= stk_rdata;
      end
      dfs_pkg::ST_EMIT_WR: begin
        if (out_free && emit_idx != '0) begin
          emit_idx <= emit_idx - dfs_pkg::VERT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register: load a result when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && (state == dfs_pkg::ST_ERR || state == dfs_pkg::ST_EMIT_WR)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == dfs_pkg::ST_ERR) begin
      out_data <= '{vertex: '0, last: 1'b1, error: 1'b1};
    end else if (out_free && state == dfs_pkg::ST_EMIT_WR) begin
      out_data <= '{vertex: post_rdata, last: (emit_idx == '0), error: 1'b0};
    end
  end

  // Edge store: target vertex and next link per edge
  dfs_ram #(.WIDTH(dfs_pkg::VERT_W), .DEPTH(dfs_pkg::MAX_EDGES)) u_target_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (edge_total[dfs_pkg::EDGE_W-1:0]),
    .wdata (add_dst),
    .re    (tgt_re),
    .raddr (top_cursor[dfs_pkg::EDGE_W-1:0]),
    .rdata (tgt_rdata)
  );

  dfs_ram #(.WIDTH(dfs_pkg::LINK_W), .DEPTH(dfs_pkg::MAX_EDGES)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .re    (lnk_re),
    .raddr (top_cursor[dfs_pkg::EDGE_W-1:0]),
    .rdata (lnk_rdata)
  );

  // Per-vertex list head and tail; valid only where nonempty is set
  dfs_ram #(.WIDTH(dfs_pkg::EDGE_W), .DEPTH(dfs_pkg::MAX_VERTICES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (add_src),
    .wdata (edge_total[dfs_pkg::EDGE_W-1:0]),
    .re    (head_re),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  dfs_ram #(.WIDTH(dfs_pkg::EDGE_W), .DEPTH(dfs_pkg::MAX_VERTICES)) u_tail_ram (
    .clk   (clk),
    .we    (tail_we),
    .waddr (add_src),
    .wdata (edge_total[dfs_pkg::EDGE_W-1:0]),
    .re    (tail_re),
    .raddr (add_src),
    .rdata (tail_rdata)
  );

  // Postorder record
  dfs_ram #(.WIDTH(dfs_pkg::VERT_W), .DEPTH(dfs_pkg::MAX_VERTICES)) u_post_ram (
    .clk   (clk),
    .we    (post_we),
    .waddr (rec[dfs_pkg::VERT_W-1:0]),
    .wdata (post_wdata),
    .re    (post_re),
    .raddr (emit_idx),
    .rdata (post_rdata)
  );

  // Walk stack below the top entry
  dfs_ram #(.WIDTH(dfs_pkg::STK_W), .DEPTH(dfs_pkg::MAX_VERTICES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_m1[dfs_pkg::VERT_W-1:0]),
    .wdata ({top_vertex, top_cursor}),
    .re    (stk_re),
    .raddr (depth_m2[dfs_pkg::VERT_W-1:0]),
    .rdata (stk_rdata)
  );

`ifndef SYNTH
  // Walk stack never overflows
  assert property (@(posedge clk) disable iff (rst)
    depth <= dfs_pkg::CNT_W'(dfs_pkg::MAX_VERTICES))
    else $error("walk stack depth out of range");

  // Stack is empty whenever the block takes a new request
  assert property (@(posedge clk) disable iff (rst)
    (state == dfs_pkg::ST_IDLE) |-> (depth == '0))
    else $error("walk stack not empty in idle");

  // Record never exceeds the vertices in use during a sort
  assert property (@(posedge clk) disable iff (rst)
    (state != dfs_pkg::ST_IDLE) |-> (rec <= live_count))
    else $error("postorder record too long");

  // Edge count stays within the store
  assert property (@(posedge clk) disable iff (rst)
    edge_total <= (dfs_pkg::EDGE_W + 1)'(dfs_pkg::MAX_EDGES))
    else $error("edge count beyond store size");

  // Error results always close their response
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> (out_data.last && out_data.vertex == '0))
    else $error("error result malformed");
`endif

endmodule

### tb/sv/dfs_topological_sort_tb.sv
// Self-checking testbench for the DFS topological sorter: edge requests, sort orders, errors.
module dfs_topological_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS   = 320;
  localparam int FILL_AFTER   = 40;
  localparam int HOLD_CYCLES  = 600;
  localparam int WATCHDOG_MAX = 10000;
  localparam int SETTLE_WAIT  = 8;
  localparam int DRAIN_WAIT   = 24;
  localparam logic [dfs_pkg::CFG_ADDR_W-1:0] VCOUNT_ADDR =
    dfs_pkg::CFG_ADDR_W'(4 * dfs_pkg::REG_VERTEX_COUNT);

  // Edge-list mirror of the sorter: predicts errors and sort orders in request order
  class order_board;
    logic [dfs_pkg::VERT_W-1:0] edge_dst  [dfs_pkg::MAX_EDGES];
    logic [dfs_pkg::LINK_W-1:0] edge_next [dfs_pkg::MAX_EDGES];
    logic [dfs_pkg::LINK_W-1:0] head [dfs_pkg::MAX_VERTICES];
    logic [dfs_pkg::LINK_W-1:0] tail [dfs_pkg::MAX_VERTICES];
    int unsigned                edge_cnt;
    logic [dfs_pkg::CNT_W-1:0]  vcount;
    dfs_pkg::out_res_t          order_q[$];
    int                         errors;

    function new();
      foreach (head[v]) begin
        head[v] = dfs_pkg::NIL_LINK;
        tail[v] = dfs_pkg::NIL_LINK;
      end
      edge_cnt = 0;
      vcount   = dfs_pkg::VCOUNT_RESET;
      errors   = 0;
    endfunction

    function int pending();
      return order_q.size();
    endfunction

    function void note_request(dfs_pkg::in_req_t r);
      int unsigned                live, rec_n, depth, v, k;
      logic [dfs_pkg::VERT_W-1:0] rec   [dfs_pkg::MAX_VERTICES];
      logic [dfs_pkg::VERT_W-1:0] stk_v [dfs_pkg::MAX_VERTICES];
      logic [dfs_pkg::LINK_W-1:0] stk_c [dfs_pkg::MAX_VERTICES];
      logic [dfs_pkg::LINK_W-1:0] cur;
      logic [dfs_pkg::VERT_W-1:0] child;
      logic [63:0]                seen;
      dfs_pkg::out_res_t          res;
      // a count of zero acts as one, anything above the maximum as the maximum
      if (vcount == 0) live = 1;
      else if (vcount > dfs_pkg::MAX_VERTICES) live = dfs_pkg::MAX_VERTICES;
      else live = vcount;
      case (r.cmd)
        dfs_pkg::CMD_CLEAR: begin
          foreach (head[i]) begin
            head[i] = dfs_pkg::NIL_LINK;
            tail[i] = dfs_pkg::NIL_LINK;
          end
          edge_cnt = 0;
        end
        dfs_pkg::CMD_ADD: begin
          if (r.src_vertex >= live || r.dst_vertex >= live
              || edge_cnt >= dfs_pkg::MAX_EDGES) begin
            res.vertex = '0;
            res.last   = 1'b1;
            res.error  = 1'b1;
            order_q.insert(order_q.size(), res);
          end else begin
            // append to the source list, keeping insertion order
            edge_dst[edge_cnt]  = r.dst_vertex;
            edge_next[edge_cnt] = dfs_pkg::NIL_LINK;
            if (head[r.src_vertex] == dfs_pkg::NIL_LINK)
              head[r.src_vertex] = dfs_pkg::LINK_W'(edge_cnt);
            else
              edge_next[tail[r.src_vertex]] = dfs_pkg::LINK_W'(edge_cnt);
            tail[r.src_vertex] = dfs_pkg::LINK_W'(edge_cnt);
            edge_cnt++;
          end
        end
        dfs_pkg::CMD_SORT: begin
          seen  = '0;
          rec_n = 0;
          // vertices without out-edges go first, in index order
          for (v = 0; v < live; v++) begin
            if (head[v] == dfs_pkg::NIL_LINK) begin
              seen[v]      = 1'b1;
              rec[rec_n++] = dfs_pkg::VERT_W'(v);
            end
          end
          // walk from each unvisited root; record each vertex when it is finished
          for (v = 0; v < live; v++) begin
            if (seen[v]) continue;
            seen[v]  = 1'b1;
            stk_v[0] = dfs_pkg::VERT_W'(v);
            stk_c[0] = head[v];
            depth    = 1;
            while (depth > 0) begin
              cur = stk_c[depth-1];
              if (cur >= dfs_pkg::NIL_LINK) begin
                rec[rec_n++] = stk_v[depth-1];
                depth--;
              end else begin
                child = edge_dst[cur];
                stk_c[depth-1] = edge_next[cur];
                if (child < live && !seen[child]) begin
                  seen[child]  = 1'b1;
                  stk_v[depth] = child;
                  stk_c[depth] = head[child];
                  depth++;
                end
              end
            end
          end
          // emit the record reversed
          for (k = 0; k < rec_n; k++) begin
            res.vertex = rec[rec_n-1-k];
            res.last   = (k == rec_n - 1);
            res.error  = 1'b0;
            order_q.insert(order_q.size(), res);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(dfs_pkg::out_res_t got);
      dfs_pkg::out_res_t want;
      if (order_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got vertex %0d last %0d error %0d",
                 $time, got.vertex, got.last, got.error);
        return;
      end
      want = order_q.pop_front();
      if (got.vertex !== want.vertex) begin
        errors++;
        $display("%0t: vertex mismatch: expected %0d, got %0d", $time, want.vertex, got.vertex);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, got.last);
      end
      if (got.error !== want.error) begin
        errors++;
        $display("%0t: error flag mismatch: expected %0d, got %0d", $time, want.error, got.error);
      end
    endfunction
  endclass

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  dfs_pkg::in_req_t               in_data  = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  dfs_pkg::out_res_t              out_data;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [dfs_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [dfs_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [dfs_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  order_board  sb = new();
  bit          quiet      = 1'b0;
  bit          src_noisy  = 1'b1;
  bit          sink_noisy = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_run   = 0;

  dfs_topological_sort u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // Offer one request, with an optional gap first, and hold it until accepted
  task automatic send(dfs_pkg::cmd_t c, int unsigned s, int unsigned d);
    dfs_pkg::in_req_t r;
    bit               go;
    int unsigned      gap;
    r.cmd        = c;
    r.src_vertex = s[dfs_pkg::VERT_W-1:0];
    r.dst_vertex = d[dfs_pkg::VERT_W-1:0];
    if (!quiet && src_noisy && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    sb.note_request(r);
  endtask

  // Drop valid and wait until every expected result is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Write the vertex count register: setup cycle, then access cycle
  task automatic write_count(int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VCOUNT_ADDR;
    pwdata  <= dfs_pkg::CFG_DATA_W'(val & 127);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.vcount = dfs_pkg::CNT_W'(val & 127);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) sink_noisy = !sink_noisy;
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !quiet && sink_noisy && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check results mid-cycle, where the handshake is stable
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: end the run after a long stretch with no handshake on any port
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_MAX) begin
      $display("dfs_topological_sort_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned n_rand, n, k, live, nadd;
    bit          fill_done;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty graph at reset count, with the result side held off so requests back up
    hold_req = 1'b1;
    send(dfs_pkg::CMD_SORT, 0, 0);
    send(dfs_pkg::CMD_ADD, 63, 0);
    send(dfs_pkg::CMD_ADD, 0, 63);
    send(dfs_pkg::CMD_ADD, 5, 5);
    send(dfs_pkg::CMD_ADD, 0, 1);
    send(dfs_pkg::CMD_UNUSED, 63, 63);
    send(dfs_pkg::CMD_SORT, 63, 63);
    send(dfs_pkg::CMD_CLEAR, 0, 0);
    send(dfs_pkg::CMD_SORT, 0, 0);

    // zero count acts as one vertex
    settle();
    write_count(0);
    send(dfs_pkg::CMD_ADD, 0, 0);
    send(dfs_pkg::CMD_ADD, 1, 0);
    send(dfs_pkg::CMD_SORT, 0, 0);
    send(dfs_pkg::CMD_CLEAR, 0, 0);

    // small graph with a cycle, a bad source and a bad destination
    settle();
    write_count(8);
    send(dfs_pkg::CMD_ADD, 0, 1);
    send(dfs_pkg::CMD_ADD, 1, 2);
    send(dfs_pkg::CMD_ADD, 2, 0);
    send(dfs_pkg::CMD_ADD, 3, 6);
    send(dfs_pkg::CMD_ADD, 8, 0);
    send(dfs_pkg::CMD_ADD, 0, 8);
    send(dfs_pkg::CMD_SORT, 0, 0);

    // count lowered under a loaded graph: the edge to vertex 6 is skipped
    settle();
    write_count(4);
    send(dfs_pkg::CMD_SORT, 0, 0);

    // count above the maximum acts as the maximum
    settle();
    write_count(127);
    send(dfs_pkg::CMD_ADD, 63, 62);
    send(dfs_pkg::CMD_SORT, 0, 0);
    send(dfs_pkg::CMD_CLEAR, 0, 0);

    // random phases: clear, load random edges, sort
    n_rand    = 0;
    fill_done = 1'b0;
    while (n_rand < RAND_ITEMS) begin
      if (n_rand + 60 >= RAND_ITEMS) quiet = 1'b1;
      settle();
      if (!fill_done && n_rand >= FILL_AFTER) begin
        // fill the store past its capacity, then sort the full graph
        write_count(64);
        src_noisy = 1'b1;
        send(dfs_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        for (k = 0; k < dfs_pkg::MAX_EDGES + 6; k++)
          send(dfs_pkg::CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
        send(dfs_pkg::CMD_SORT, $urandom_range(0, 63), $urandom_range(0, 63));
        n_rand    = n_rand + dfs_pkg::MAX_EDGES + 8;
        fill_done = 1'b1;
        continue;
      end
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 64;
        2:       n = $urandom_range(65, 127);
        3:       n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      write_count(n);
      if (n == 0) live = 1;
      else if (n > dfs_pkg::MAX_VERTICES) live = dfs_pkg::MAX_VERTICES;
      else live = n;
      src_noisy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) != 0) begin
        send(dfs_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        n_rand++;
      end
      nadd = $urandom_range(0, (live < 8) ? 3 * live : 20);
      for (k = 0; k < nadd; k++) begin
        case ($urandom_range(0, 19))
          0:       send(dfs_pkg::CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
          1:       send(dfs_pkg::CMD_SORT, $urandom_range(0, 63), $urandom_range(0, 63));
          2, 3:    send(dfs_pkg::CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
          default: send(dfs_pkg::CMD_ADD, $urandom_range(0, live - 1),
                        $urandom_range(0, live - 1));
        endcase
        n_rand++;
      end
      send(dfs_pkg::CMD_SORT, $urandom_range(0, 63), $urandom_range(0, 63));
      n_rand++;
    end

    // drain and report
    quiet = 1'b1;
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dfs_topological_sort_tb: done, clean");
    end else begin
      $display("dfs_topological_sort_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/dfs_pkg.sv
design/dfs_ram.sv
design/dfs_topological_sort.sv
tb/sv/dfs_topological_sort_tb.sv
